// File: rtl/crop_box_average_luma_downscaler_unit_macros.svh
// Assertion macros for the crop box average luma downscaler.
// Taken in by the checker module; no other dependencies.
`ifndef CROP_BOX_AVERAGE_LUMA_DOWNSCALER_UNIT_MACROS_SVH
`define CROP_BOX_AVERAGE_LUMA_DOWNSCALER_UNIT_MACROS_SVH

// Check a property while out of reset.
`define CBALD_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define CBALD_ASSERT_ALL(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/cbald_pkg.sv
// Shared constants and types for the crop box average luma downscaler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cbald_pkg;
   localparam int CFG_W       = 12;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 12;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 12'd320;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd240;

   localparam logic [15:0] LUMA_RED   = 16'd77;
   localparam logic [15:0] LUMA_GREEN = 16'd150;
   localparam logic [15:0] LUMA_BLUE  = 16'd29;
   localparam int          LUMA_SHIFT = 8;
   localparam logic [7:0]  CODE_FLIP  = 8'h80;

   localparam int RECIP_SHIFT = 24;

   typedef struct packed {
      logic not_full;
      logic not_empty;
   } queue_status_type;
endpackage
`default_nettype wire

// File: rtl/cbald_req_if.sv
// Pixel channel interface: valid/ready handshake with one BGR pixel.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface cbald_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] blue;
   logic [7:0] green;
   logic [7:0] red;
   logic       frame_start;

   modport source (output valid, blue, green, red, frame_start, input ready);
   modport sink (input valid, blue, green, red, frame_start, output ready);
endinterface
`default_nettype wire

// File: rtl/cbald_rsp_if.sv
// Cell channel interface: valid/ready handshake with one output grid cell.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface cbald_rsp_if #(
   parameter int COL_W = 7,
   parameter int ROW_W = 7
);
   logic              valid;
   logic              ready;
   logic signed [7:0] luma_code;
   logic [COL_W-1:0]  cell_col;
   logic [ROW_W-1:0]  cell_row;
   logic              frame_done;

   modport source (output valid, luma_code, cell_col, cell_row, frame_done, input ready);
   modport sink (input valid, luma_code, cell_col, cell_row, frame_done, output ready);
endinterface
`default_nettype wire

// File: rtl/crop_box_average_luma_downscaler_unit.sv
// Top level of the crop box average luma downscaler.
// Depends on cbald_pkg, cbald_req_if, cbald_rsp_if, cbald_front, cbald_queue, cbald_back.
//
// Use: pixels arrive in raster order on req_bus (BGR plus frame_start, which
// marks source position zero). The frame is cropped to its largest centred
// square and box-averaged to a GRID_WIDTH x GRID_HEIGHT grid of luma codes
// (mean XOR 0x80), delivered on rsp_bus with grid column, row and a
// frame_done flag on the last cell.
// Flow: the front end takes no new pixel while it is busy with the
// read-modify-write of the per-column accumulator memory. The back end
// pops a new block only when idle, then runs its 8-step bit-serial divider.
// A pixel closing a block is registered and pushed into the queue, then
// popped and divided before rsp_bus.valid rises. A two-entry queue decouples
// the two; while the output register waits on rsp_bus.ready the queue fills,
// and once it is full req_bus.ready drops until a cell leaves.
// Reset (synchronous) restores frame width 320 and height 240, clears the
// position and grid counters, and holds req_bus.ready low while the crop
// geometry settles; each csr write holds it low the same way.
`timescale 1ns / 1ps
`default_nettype none
module crop_box_average_luma_downscaler_unit #(
   parameter int GRID_WIDTH     = 96,
   parameter int GRID_HEIGHT    = 96,
   parameter int MAX_FRAME_SIDE = 2048
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   cbald_req_if.sink                              req_bus,
   cbald_rsp_if.source                            rsp_bus,
   input  wire logic                              csr_write_enable,
   input  wire logic [cbald_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [cbald_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   localparam int CNT_W = $clog2((MAX_FRAME_SIDE/GRID_WIDTH+1)*(MAX_FRAME_SIDE/GRID_HEIGHT+1)+1);
   localparam int JOB_W = 2*CNT_W + 8 + $clog2(GRID_WIDTH) + $clog2(GRID_HEIGHT) + 1;

   logic                        push_valid, pop;
   logic [JOB_W-1:0]            push_data, pop_data;
   cbald_pkg::queue_status_type queue_status;

   cbald_front #(
      .GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT), .MAX_FRAME_SIDE(MAX_FRAME_SIDE)
   ) u_front (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_bus(req_bus), .queue_status(queue_status),
      .push_valid(push_valid), .push_data(push_data)
   );

   cbald_queue #(.WIDTH(JOB_W)) u_queue (
      .clock(clock), .reset(reset),
      .push(push_valid), .push_data(push_data),
      .pop(pop), .pop_data(pop_data), .status(queue_status)
   );

   cbald_back #(
      .GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT), .MAX_FRAME_SIDE(MAX_FRAME_SIDE)
   ) u_back (
      .clock(clock), .reset(reset),
      .queue_status(queue_status), .pop_data(pop_data), .pop(pop),
      .rsp_bus(rsp_bus)
   );
endmodule
`default_nettype wire

// File: rtl/cbald_front.sv
// Front end: config registers, crop geometry, pixel tracking and column accumulators.
// Depends on cbald_pkg and cbald_req_if; pushes finished blocks to the queue.
`timescale 1ns / 1ps
`default_nettype none
module cbald_front #(
   parameter int GRID_WIDTH     = 96,
   parameter int GRID_HEIGHT    = 96,
   parameter int MAX_FRAME_SIDE = 2048
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_enable,
   input  wire logic [cbald_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [cbald_pkg::CSR_DATA_W-1:0]   csr_write_data,
   cbald_req_if.sink                               req_bus,
   input  wire cbald_pkg::queue_status_type        queue_status,
   output logic                                    push_valid,
   output logic [$clog2((MAX_FRAME_SIDE/GRID_WIDTH+1)*(MAX_FRAME_SIDE/GRID_HEIGHT+1)+1)*2
                 +8+$clog2(GRID_WIDTH)+$clog2(GRID_HEIGHT)+1-1:0] push_data
);
   localparam int CNT_W = $clog2((MAX_FRAME_SIDE/GRID_WIDTH+1)*(MAX_FRAME_SIDE/GRID_HEIGHT+1)+1);
   localparam int SUM_W = CNT_W + 8;
   localparam int COL_W = $clog2(GRID_WIDTH);
   localparam int ROW_W = $clog2(GRID_HEIGHT);
   localparam int GC_W  = $clog2(GRID_WIDTH + 1);
   localparam int GR_W  = $clog2(GRID_HEIGHT + 1);
   localparam int POS_W = $clog2(MAX_FRAME_SIDE + 1);
   localparam int SIDE_FLOOR = (GRID_WIDTH > GRID_HEIGHT) ? GRID_WIDTH : GRID_HEIGHT;
   localparam longint RECIP_COL =
      ((64'd1 << cbald_pkg::RECIP_SHIFT) + GRID_WIDTH - 1) / GRID_WIDTH;
   localparam longint RECIP_ROW =
      ((64'd1 << cbald_pkg::RECIP_SHIFT) + GRID_HEIGHT - 1) / GRID_HEIGHT;
   localparam int PROD_W = POS_W + cbald_pkg::RECIP_SHIFT;

   logic [cbald_pkg::CFG_W-1:0] cfg_width_ff, cfg_height_ff;
   logic [1:0]                  settle_ff;
   logic [POS_W-1:0]            w_ff, h_ff, side_ff, ox_ff, oy_ff, side2_ff;
   logic [PROD_W-1:0]           prod_col_ff, prod_row_ff;
   logic [POS_W-1:0]            qc_ff, qr_ff;
   logic [GC_W-1:0]             rc_ff;
   logic [GR_W-1:0]             rr_ff;
   logic [POS_W-1:0]            w_cl, h_cl, side_cl, qc_cl, qr_cl;

   logic [POS_W-1:0] src_col_ff, src_row_ff, src_col_in, src_row_in;
   logic [GC_W-1:0]  gc_ff, gc_in, col_rem_ff, col_rem_in;
   logic [GR_W-1:0]  gr_ff, gr_in, row_rem_ff, row_rem_in;
   logic [POS_W-1:0] col_bnd_ff, col_bnd_in, col_start_ff, col_start_in;
   logic [POS_W-1:0] row_bnd_ff, row_bnd_in, row_start_ff, row_start_in;
   logic [GC_W:0]    col_rsum;
   logic [GR_W:0]    row_rsum;
   logic [POS_W-1:0] sc, sr, cx, cy, sc_inc, sr_inc;
   logic             in_crop, accept, live, first, emit, done;
   logic [15:0]      luma_wide;

   logic             busy_ff, live_ff, first_ff, emit_ff, done_ff;
   logic [7:0]       luma_ff;
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic [SUM_W-1:0] sum_mem [GRID_WIDTH];
   logic [CNT_W-1:0] cnt_mem [GRID_WIDTH];
   logic [SUM_W-1:0] rd_sum_ff, new_sum;
   logic [CNT_W-1:0] rd_cnt_ff, new_cnt;

   function automatic logic [POS_W-1:0] clamp_side(input logic [cbald_pkg::CFG_W-1:0] v);
      logic [15:0] vx;
      vx = 16'(v);
      if (vx < 16'(SIDE_FLOOR)) begin
         return POS_W'(SIDE_FLOOR);
      end else if (vx > 16'(MAX_FRAME_SIDE)) begin
         return POS_W'(MAX_FRAME_SIDE);
      end
      return POS_W'(vx);
   endfunction

   assign w_cl    = clamp_side(cfg_width_ff);
   assign h_cl    = clamp_side(cfg_height_ff);
   assign side_cl = (w_cl < h_cl) ? w_cl : h_cl;
   assign qc_cl   = POS_W'(prod_col_ff >> cbald_pkg::RECIP_SHIFT);
   assign qr_cl   = POS_W'(prod_row_ff >> cbald_pkg::RECIP_SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= cbald_pkg::FRAME_WIDTH_RESET;
         cfg_height_ff <= cbald_pkg::FRAME_HEIGHT_RESET;
         settle_ff     <= 2'd3;
      end else begin
         if (csr_write_enable) begin
            settle_ff <= 2'd3;
            if (csr_index == cbald_pkg::REG_FRAME_WIDTH) begin
               cfg_width_ff <= csr_write_data;
            end else if (csr_index == cbald_pkg::REG_FRAME_HEIGHT) begin
               cfg_height_ff <= csr_write_data;
            end
         end else if (settle_ff != 2'd0) begin
            settle_ff <= settle_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      w_ff        <= w_cl;
      h_ff        <= h_cl;
      side_ff     <= side_cl;
      ox_ff       <= (w_cl - side_cl) >> 1;
      oy_ff       <= (h_cl - side_cl) >> 1;
      side2_ff    <= side_ff;
      prod_col_ff <= PROD_W'(side_ff) * PROD_W'(RECIP_COL);
      prod_row_ff <= PROD_W'(side_ff) * PROD_W'(RECIP_ROW);
      qc_ff       <= qc_cl;
      qr_ff       <= qr_cl;
      rc_ff       <= GC_W'(PROD_W'(side2_ff) - PROD_W'(qc_cl) * PROD_W'(GRID_WIDTH));
      rr_ff       <= GR_W'(PROD_W'(side2_ff) - PROD_W'(qr_cl) * PROD_W'(GRID_HEIGHT));
   end

   assign req_bus.ready = !busy_ff && queue_status.not_full && (settle_ff == 2'd0);
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      sc           = req_bus.frame_start ? '0 : src_col_ff;
      sr           = req_bus.frame_start ? '0 : src_row_ff;
      in_crop      = (sc >= ox_ff) && (sc < ox_ff + side_ff) &&
                     (sr >= oy_ff) && (sr < oy_ff + side_ff);
      cx           = sc - ox_ff;
      cy           = sr - oy_ff;
      gc_in        = gc_ff;
      gr_in        = gr_ff;
      col_bnd_in   = col_bnd_ff;
      col_start_in = col_start_ff;
      col_rem_in   = col_rem_ff;
      row_bnd_in   = row_bnd_ff;
      row_start_in = row_start_ff;
      row_rem_in   = row_rem_ff;
      col_rsum     = {1'b0, col_rem_ff} + {1'b0, rc_ff};
      row_rsum     = {1'b0, row_rem_ff} + {1'b0, rr_ff};
      if (cx == '0) begin
         gc_in        = '0;
         col_bnd_in   = qc_ff;
         col_rem_in   = rc_ff;
         col_start_in = '0;
         if (cy == '0) begin
            gr_in        = '0;
            row_bnd_in   = qr_ff;
            row_rem_in   = rr_ff;
            row_start_in = '0;
         end else if (cy == row_bnd_ff) begin
            gr_in        = gr_ff + GR_W'(1);
            row_start_in = row_bnd_ff;
            if (row_rsum >= (GR_W+1)'(GRID_HEIGHT)) begin
               row_rem_in = GR_W'(row_rsum - (GR_W+1)'(GRID_HEIGHT));
               row_bnd_in = row_bnd_ff + qr_ff + POS_W'(1);
            end else begin
               row_rem_in = GR_W'(row_rsum);
               row_bnd_in = row_bnd_ff + qr_ff;
            end
         end
      end else if (cx == col_bnd_ff) begin
         gc_in        = gc_ff + GC_W'(1);
         col_start_in = col_bnd_ff;
         if (col_rsum >= (GC_W+1)'(GRID_WIDTH)) begin
            col_rem_in = GC_W'(col_rsum - (GC_W+1)'(GRID_WIDTH));
            col_bnd_in = col_bnd_ff + qc_ff + POS_W'(1);
         end else begin
            col_rem_in = GC_W'(col_rsum);
            col_bnd_in = col_bnd_ff + qc_ff;
         end
      end
      live  = in_crop && (gc_in < GC_W'(GRID_WIDTH)) && (gr_in < GR_W'(GRID_HEIGHT));
      first = (cx == col_start_in) && (cy == row_start_in);
      emit  = (cx + POS_W'(1) == col_bnd_in) && (cy + POS_W'(1) == row_bnd_in);
      done  = (gc_in == GC_W'(GRID_WIDTH - 1)) && (gr_in == GR_W'(GRID_HEIGHT - 1));
      sc_inc = sc + POS_W'(1);
      sr_inc = sr + POS_W'(1);
      if (sc_inc >= w_ff) begin
         src_col_in = '0;
         src_row_in = (sr_inc >= h_ff) ? '0 : sr_inc;
      end else begin
         src_col_in = sc_inc;
         src_row_in = sr;
      end
      luma_wide = 16'(req_bus.red) * cbald_pkg::LUMA_RED +
                  16'(req_bus.green) * cbald_pkg::LUMA_GREEN +
                  16'(req_bus.blue) * cbald_pkg::LUMA_BLUE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         src_col_ff   <= '0;
         src_row_ff   <= '0;
         gc_ff        <= '0;
         gr_ff        <= '0;
         col_bnd_ff   <= '0;
         row_bnd_ff   <= '0;
         col_start_ff <= '0;
         row_start_ff <= '0;
         col_rem_ff   <= '0;
         row_rem_ff   <= '0;
      end else begin
         busy_ff <= accept;
         if (accept) begin
            src_col_ff <= src_col_in;
            src_row_ff <= src_row_in;
            if (in_crop) begin
               gc_ff        <= gc_in;
               gr_ff        <= gr_in;
               col_bnd_ff   <= col_bnd_in;
               row_bnd_ff   <= row_bnd_in;
               col_start_ff <= col_start_in;
               row_start_ff <= row_start_in;
               col_rem_ff   <= col_rem_in;
               row_rem_ff   <= row_rem_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         live_ff  <= live;
         first_ff <= first;
         emit_ff  <= emit;
         done_ff  <= done;
         luma_ff  <= luma_wide[15:cbald_pkg::LUMA_SHIFT];
         col_ff   <= COL_W'(gc_in);
         row_ff   <= ROW_W'(gr_in);
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff && live_ff) begin
         sum_mem[col_ff] <= new_sum;
         cnt_mem[col_ff] <= new_cnt;
      end
      if (accept && live) begin
         rd_sum_ff <= sum_mem[COL_W'(gc_in)];
         rd_cnt_ff <= cnt_mem[COL_W'(gc_in)];
      end
   end

   assign new_sum    = first_ff ? SUM_W'(luma_ff) : rd_sum_ff + SUM_W'(luma_ff);
   assign new_cnt    = first_ff ? CNT_W'(1) : rd_cnt_ff + CNT_W'(1);
   assign push_valid = busy_ff && live_ff && emit_ff;
   assign push_data  = {new_sum, new_cnt, col_ff, row_ff, done_ff};
endmodule
`default_nettype wire

// File: rtl/cbald_queue.sv
// Two-entry queue between the front end and the back end.
// Depends on cbald_pkg for the status struct.
`timescale 1ns / 1ps
`default_nettype none
module cbald_queue #(
   parameter int WIDTH = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire logic [WIDTH-1:0]            push_data,
   input  wire logic                        pop,
   output logic [WIDTH-1:0]                 pop_data,
   output cbald_pkg::queue_status_type      status
);
   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data         = entry_ff[rd_ptr_ff];
   assign status.not_full  = (count_ff != 2'd2);
   assign status.not_empty = (count_ff != 2'd0);
endmodule
`default_nettype wire

// File: rtl/cbald_back.sv
// Back end: bit-serial mean divider and output register for grid cells.
// Depends on cbald_pkg and cbald_rsp_if; pops blocks from the queue.
`timescale 1ns / 1ps
`default_nettype none
module cbald_back #(
   parameter int GRID_WIDTH     = 96,
   parameter int GRID_HEIGHT    = 96,
   parameter int MAX_FRAME_SIDE = 2048
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire cbald_pkg::queue_status_type    queue_status,
   input  wire logic [$clog2((MAX_FRAME_SIDE/GRID_WIDTH+1)*(MAX_FRAME_SIDE/GRID_HEIGHT+1)+1)*2
                      +8+$clog2(GRID_WIDTH)+$clog2(GRID_HEIGHT)+1-1:0] pop_data,
   output logic                                pop,
   cbald_rsp_if.source                         rsp_bus
);
   localparam int CNT_W = $clog2((MAX_FRAME_SIDE/GRID_WIDTH+1)*(MAX_FRAME_SIDE/GRID_HEIGHT+1)+1);
   localparam int SUM_W = CNT_W + 8;
   localparam int COL_W = $clog2(GRID_WIDTH);
   localparam int ROW_W = $clog2(GRID_HEIGHT);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [SUM_W-1:0] job_sum;
   logic [CNT_W-1:0] job_cnt;
   logic [COL_W-1:0] job_col;
   logic [ROW_W-1:0] job_row;
   logic             job_done;
   logic [CNT_W-1:0] rem_ff, cnt_ff;
   logic [7:0]       low_ff, quot_ff, quot_in;
   logic [2:0]       step_ff;
   logic [CNT_W:0]   trial;
   logic             fits;
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic             done_ff;
   logic [7:0]       code_ff;

   assign {job_sum, job_cnt, job_col, job_row, job_done} = pop_data;
   assign pop     = (state_ff == ST_IDLE) && queue_status.not_empty;
   assign trial   = {rem_ff, low_ff[7]};
   assign fits    = trial >= {1'b0, cnt_ff};
   assign quot_in = {quot_ff[6:0], fits};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (queue_status.not_empty) state_in = ST_DIV;
         ST_DIV:  if (step_ff == 3'd7) state_in = ST_OUT;
         ST_OUT:  if (rsp_bus.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rem_ff  <= job_sum[SUM_W-1:8];
         low_ff  <= job_sum[7:0];
         cnt_ff  <= job_cnt;
         col_ff  <= job_col;
         row_ff  <= job_row;
         done_ff <= job_done;
         step_ff <= 3'd0;
      end else if (state_ff == ST_DIV) begin
         rem_ff  <= fits ? CNT_W'(trial - {1'b0, cnt_ff}) : CNT_W'(trial);
         low_ff  <= {low_ff[6:0], 1'b0};
         quot_ff <= quot_in;
         step_ff <= step_ff + 3'd1;
         if (step_ff == 3'd7) begin
            code_ff <= ((cnt_ff == '0) ? 8'd0 : quot_in) ^ cbald_pkg::CODE_FLIP;
         end
      end
   end

   assign rsp_bus.valid      = (state_ff == ST_OUT);
   assign rsp_bus.luma_code  = code_ff;
   assign rsp_bus.cell_col   = col_ff;
   assign rsp_bus.cell_row   = row_ff;
   assign rsp_bus.frame_done = done_ff;
endmodule
`default_nettype wire

// File: rtl/cbald_checker.sv
// Port-level checks for the crop box average luma downscaler, bound to the top level.
// Depends on crop_box_average_luma_downscaler_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "crop_box_average_luma_downscaler_unit_macros.svh"
module cbald_checker #(
   parameter int GRID_WIDTH  = 96,
   parameter int GRID_HEIGHT = 96
) (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [$clog2(GRID_WIDTH)-1:0]  cell_col,
   input wire logic [$clog2(GRID_HEIGHT)-1:0] cell_row,
   input wire logic                           frame_done,
   input wire logic                           csr_write_enable
);
   `CBALD_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "cell dropped while stalled")
   `CBALD_ASSERT_RST(a_col_range, clock, reset, rsp_valid |-> (32'(cell_col) < GRID_WIDTH), "cell column outside grid")
   `CBALD_ASSERT_RST(a_done_last, clock, reset, rsp_valid && frame_done |-> (32'(cell_col) == GRID_WIDTH - 1) && (32'(cell_row) == GRID_HEIGHT - 1), "frame_done not on last cell")
   `CBALD_ASSERT_ALL(a_reset_quiet, clock, reset |=> !rsp_valid, "cell shown after reset")
   `CBALD_ASSERT_ALL(a_csr_settle, clock, csr_write_enable |=> !req_ready, "pixel taken before geometry settled")
endmodule

bind crop_box_average_luma_downscaler_unit cbald_checker #(
   .GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)
) u_checker (
   .clock(clock), .reset(reset),
   .req_ready(req_bus.ready),
   .rsp_valid(rsp_bus.valid), .rsp_ready(rsp_bus.ready),
   .cell_col(rsp_bus.cell_col), .cell_row(rsp_bus.cell_row),
   .frame_done(rsp_bus.frame_done),
   .csr_write_enable(csr_write_enable)
);
`default_nettype wire

// File: dv/crop_box_average_luma_downscaler_unit_tb.sv
// Self-checking testbench for crop_box_average_luma_downscaler_unit: drives raster pixel
// streams through several frame geometries and checks every averaged luma cell in order.
// Depends on cbald_pkg, cbald_req_if, cbald_rsp_if and the unit itself.
`timescale 1ns / 1ps

module crop_box_average_luma_downscaler_unit_tb;
   localparam int GRID_COLS = 96;
   localparam int GRID_ROWS = 96;
   localparam int SIDE_MAX  = 2048;

   typedef struct packed {
      logic signed [7:0] luma_code;
      logic [6:0]        cell_col;
      logic [6:0]        cell_row;
      logic              frame_done;
   } luma_cell_type;

   class luma_cell_board;
      logic [11:0]    width_reg;
      logic [11:0]    height_reg;
      int unsigned    src_col, src_row, grid_col, grid_row, col_end, row_end;
      int unsigned    sums[GRID_COLS];
      int unsigned    counts[GRID_COLS];
      luma_cell_type  cells_due[$];
      int             failures;

      function void restart();
         width_reg  = cbald_pkg::FRAME_WIDTH_RESET;
         height_reg = cbald_pkg::FRAME_HEIGHT_RESET;
         src_col = 0; src_row = 0; grid_col = 0; grid_row = 0; col_end = 0; row_end = 0;
         failures = 0;
      endfunction

      function void set_reg(logic [cbald_pkg::CSR_INDEX_W-1:0] idx, logic [11:0] val);
         if (idx == cbald_pkg::REG_FRAME_WIDTH) width_reg = val;
         else height_reg = val;
      endfunction

      function int unsigned clamp_side(int unsigned v);
         if (v < GRID_COLS) return GRID_COLS;
         if (v > SIDE_MAX) return SIDE_MAX;
         return v;
      endfunction

      function void note_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic fs);
         int unsigned w, h, side, ox, oy, sc, sr, cx, cy, luma, cs, rs, n, mean;
         luma_cell_type c;
         w = clamp_side(width_reg);
         h = clamp_side(height_reg);
         side = (w < h) ? w : h;
         ox = (w - side) / 2;
         oy = (h - side) / 2;
         if (fs) begin
            src_col = 0;
            src_row = 0;
         end
         sc = src_col;
         sr = src_row;
         if (sc >= ox && sc < ox + side && sr >= oy && sr < oy + side) begin
            cx = sc - ox;
            cy = sr - oy;
            luma = (r * 77 + g * 150 + b * 29) >> 8;
            if (cx == 0) begin
               grid_col = 0;
               col_end = side / GRID_COLS;
               if (cy == 0) begin
                  grid_row = 0;
                  row_end = side / GRID_ROWS;
               end else if (cy == row_end) begin
                  grid_row++;
                  row_end = ((grid_row + 1) * side) / GRID_ROWS;
               end
            end else if (cx == col_end) begin
               grid_col++;
               col_end = ((grid_col + 1) * side) / GRID_COLS;
            end
            if (grid_col < GRID_COLS && grid_row < GRID_ROWS) begin
               cs = (grid_col * side) / GRID_COLS;
               rs = (grid_row * side) / GRID_ROWS;
               if (cx == cs && cy == rs) begin
                  sums[grid_col] = luma;
                  counts[grid_col] = 1;
               end else begin
                  sums[grid_col] += luma;
                  counts[grid_col] += 1;
               end
               if (cx + 1 == col_end && cy + 1 == row_end) begin
                  n = counts[grid_col];
                  mean = n ? sums[grid_col] / n : 0;
                  c.luma_code  = 8'(mean) ^ cbald_pkg::CODE_FLIP;
                  c.cell_col   = 7'(grid_col);
                  c.cell_row   = 7'(grid_row);
                  c.frame_done = (grid_col == GRID_COLS - 1 && grid_row == GRID_ROWS - 1);
                  cells_due.push_back(c);
               end
            end
         end
         sc++;
         if (sc >= w) begin
            sc = 0;
            sr++;
            if (sr >= h) sr = 0;
         end
         src_col = sc;
         src_row = sr;
      endfunction

      function void check_cell(luma_cell_type got);
         luma_cell_type want;
         if (cells_due.size() == 0) begin
            $error("unexpected cell col %0d row %0d", got.cell_col, got.cell_row);
            failures++;
            return;
         end
         want = cells_due.pop_front();
         if (got.luma_code !== want.luma_code) begin
            $error("luma_code: expected %0d, got %0d", want.luma_code, got.luma_code);
            failures++;
         end
         if (got.cell_col !== want.cell_col) begin
            $error("cell_col: expected %0d, got %0d", want.cell_col, got.cell_col);
            failures++;
         end
         if (got.cell_row !== want.cell_row) begin
            $error("cell_row: expected %0d, got %0d", want.cell_row, got.cell_row);
            failures++;
         end
         if (got.frame_done !== want.frame_done) begin
            $error("frame_done: expected %0d, got %0d", want.frame_done, got.frame_done);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                              csr_write_enable;
   logic [cbald_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [cbald_pkg::CSR_DATA_W-1:0]  csr_write_data;

   cbald_req_if req_bus ();
   cbald_rsp_if rsp_bus ();

   crop_box_average_luma_downscaler_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   luma_cell_board board;
   bit quiet_req;
   bit quiet_rsp;
   int rsp_stall;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #20000000;
      $display("tb: failure");
      $finish;
   end

   // hold ready low for a drawn number of cycles after each accepted cell
   always @(negedge clock) begin
      if (reset || rsp_stall == 0) begin
         rsp_bus.ready <= !reset;
      end else begin
         rsp_bus.ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         board.check_cell({rsp_bus.luma_code, rsp_bus.cell_col, rsp_bus.cell_row,
                           rsp_bus.frame_done});
         if ($urandom_range(63) == 0) quiet_rsp = !quiet_rsp;
         rsp_stall <= quiet_rsp ? 0 : $urandom_range(9);
      end
   end

   task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic fs);
      int gap;
      if ($urandom_range(63) == 0) quiet_req = !quiet_req;
      gap = quiet_req ? 0 : $urandom_range(9);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.blue        <= b;
      req_bus.green       <= g;
      req_bus.red         <= r;
      req_bus.frame_start <= fs;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_pixel(b, g, r, fs);
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (board.cells_due.size() != 0) @(posedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_reg(logic [cbald_pkg::CSR_INDEX_W-1:0] idx, logic [11:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      board.set_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic set_frame(logic [11:0] w, logic [11:0] h);
      drain();
      write_reg(cbald_pkg::REG_FRAME_WIDTH, w);
      write_reg(cbald_pkg::REG_FRAME_HEIGHT, h);
   endtask

   // first item of a phase carries frame_start; later ones only at the given odds
   task automatic random_pixels(int count, int fs_odds);
      logic fs;
      for (int i = 0; i < count; i++) begin
         fs = (i == 0) || (fs_odds > 0 && $urandom_range(fs_odds - 1) == 0);
         send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255), fs);
      end
   endtask

   initial begin
      logic [7:0] lv;
      board = new();
      board.restart();
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = cbald_pkg::REG_FRAME_WIDTH;
      csr_write_data   = '0;
      req_bus.valid       = 1'b0;
      req_bus.blue        = '0;
      req_bus.green       = '0;
      req_bus.red         = '0;
      req_bus.frame_start = 1'b0;
      rsp_bus.ready       = 1'b0;
      rsp_stall = 0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      random_pixels(380, 0);

      // smallest frame: every pixel closes a cell
      set_frame(12'd96, 12'd96);
      for (int i = 0; i < 24; i++) begin
         lv = (i < 8) ? 8'hFF : ((i < 16) ? 8'hAA : 8'h55);
         send_pixel(i[0] ? lv : ~lv, i[1] ? lv : ~lv, i[2] ? lv : ~lv, i == 0);
      end
      for (int i = 24; i < 200; i++)
         send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255),
                    $urandom_range(49) == 0);

      // below the floor: clamps to 96 x 100
      set_frame(12'd0, 12'd100);
      random_pixels(250, 0);

      set_frame(12'd150, 12'd97);
      random_pixels(200, 0);

      // above the ceiling: clamps to 2048 x 2048
      set_frame(12'hFFF, 12'hFFF);
      random_pixels(100, 0);

      set_frame(12'd200, 12'd100);
      random_pixels(200, 60);

      drain();
      if (board.failures == 0 && board.cells_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
